/* hw/rtl/sic_pkg.sv */
// sic_pkg: shared constants and types for the sensor integer compensation block
// holds register indexes, datapath constants and the divider side-band struct
// no dependencies
`default_nettype none

package sic_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] REG_TEMP    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PRES_LO = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PRES_HI = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_PRES_P9 = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_HUM     = 3'd4;

  localparam int unsigned DivSteps = 64;
  localparam int unsigned Latency  = 80;

  localparam logic signed [63:0] TFINE_OFS   = 64'sd128000;
  localparam logic signed [63:0] PRES_FULL   = 64'sd1048576;
  localparam logic signed [63:0] PRES_SCALE  = 64'sd3125;
  localparam logic signed [63:0] PRES_ONE47  = 64'sh0000_8000_0000_0000;
  localparam logic signed [31:0] HUM_TOFS    = 32'sd76800;
  localparam logic signed [31:0] HUM_RND14   = 32'sd16384;
  localparam logic signed [31:0] HUM_K15     = 32'sd32768;
  localparam logic signed [31:0] HUM_K21     = 32'sd2097152;
  localparam logic signed [31:0] HUM_RND13   = 32'sd8192;
  localparam logic [31:0]        HUM_CLAMP   = 32'd419430400;
  localparam logic [16:0]        HUM_OUT_MAX = 17'd102400;

  typedef struct packed {
    logic signed [31:0] tcent;
    logic signed [31:0] tfine;
    logic [16:0]        hum;
    logic               neg;
    logic               invalid;
  } sic_side_t;

endpackage

`default_nettype wire

/* hw/rtl/sensor_integer_compensation.sv */
// sensor_integer_compensation: fully pipelined integer compensation datapath
// temperature, humidity and 64-bit pressure paths with a bit-per-stage divider
// depends on sic_pkg
`default_nettype none

// Usage
//   configuration: cfg_we/cfg_index/cfg_wdata write one coefficient register per
//   cycle (0 temperature, 1 pressure low, 2 pressure high, 3 P9, 4 humidity);
//   write only while no measurement is in flight.
//   input: a raw measurement word is taken at each edge with start high and busy
//   low; busy stays low, so one word can enter every cycle.
//   output: out_valid marks one result word for a single cycle, in input order.
//   Throughput is one word per cycle.
//   pipeline: 3 stages temperature, 7 stages pressure/humidity prep,
//   64 restoring divider stages (one quotient bit each), 6 stages pressure finish.
//   reset: clears coefficients and all pipeline valid bits; words in flight are
//   dropped. The receiver cannot stall, so the pipeline never holds.
module sensor_integer_compensation (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [19:0]                  in_adc_temperature,
  input  wire logic [19:0]                  in_adc_pressure,
  input  wire logic [15:0]                  in_adc_humidity,
  output logic                              out_valid,
  output logic signed [31:0]                out_temperature_centi,
  output logic signed [31:0]                out_fine_temperature,
  output logic [31:0]                       out_pressure_q24_8,
  output logic [16:0]                       out_humidity_q22_10,
  output logic                              out_pressure_invalid,
  input  wire logic                         cfg_we,
  input  wire logic [sic_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [sic_pkg::CfgDataW-1:0] cfg_wdata
);

  // coefficient registers
  logic [47:0] temp_r;
  logic [63:0] pres_lo_r;
  logic [63:0] pres_hi_r;
  logic [15:0] pres_p9_r;
  logic [63:0] hum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_r    <= '0;
      pres_lo_r <= '0;
      pres_hi_r <= '0;
      pres_p9_r <= '0;
      hum_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sic_pkg::REG_TEMP:    temp_r    <= cfg_wdata[47:0];
        sic_pkg::REG_PRES_LO: pres_lo_r <= cfg_wdata;
        sic_pkg::REG_PRES_HI: pres_hi_r <= cfg_wdata;
        sic_pkg::REG_PRES_P9: pres_p9_r <= cfg_wdata[15:0];
        sic_pkg::REG_HUM:     hum_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // coefficient fields
  logic signed [31:0] t1, t2, t3;
  logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic signed [31:0] h1, h2, h3, h4, h5, h6;

  assign t1 = $signed({16'd0, temp_r[15:0]});
  assign t2 = 32'($signed(temp_r[31:16]));
  assign t3 = 32'($signed(temp_r[47:32]));
  assign p1 = $signed({48'd0, pres_lo_r[15:0]});
  assign p2 = 64'($signed(pres_lo_r[31:16]));
  assign p3 = 64'($signed(pres_lo_r[47:32]));
  assign p4 = 64'($signed(pres_lo_r[63:48]));
  assign p5 = 64'($signed(pres_hi_r[15:0]));
  assign p6 = 64'($signed(pres_hi_r[31:16]));
  assign p7 = 64'($signed(pres_hi_r[47:32]));
  assign p8 = 64'($signed(pres_hi_r[63:48]));
  assign p9 = 64'($signed(pres_p9_r));
  assign h1 = $signed({24'd0, hum_r[7:0]});
  assign h2 = 32'($signed(hum_r[23:8]));
  assign h3 = $signed({24'd0, hum_r[31:24]});
  assign h4 = 32'($signed(hum_r[43:32]));
  assign h5 = 32'($signed(hum_r[55:44]));
  assign h6 = 32'($signed(hum_r[63:56]));

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // valid bits for the front stages 1..9
  logic [9:1] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[8:1], accept};
    end
  end

  // stage 1: temperature products
  logic signed [31:0] s1_at2_r, s1_bb_r;
  logic [19:0]        s1_ap_r;
  logic [15:0]        s1_ah_r;
  logic signed [31:0] s1_a, s1_b;

  always_comb begin
    s1_a = $signed({15'd0, in_adc_temperature[19:3]}) - (t1 <<< 1);
    s1_b = $signed({16'd0, in_adc_temperature[19:4]}) - t1;
  end

  always_ff @(posedge clk) begin
    s1_at2_r <= s1_a * t2;
    s1_bb_r  <= s1_b * s1_b;
    s1_ap_r  <= in_adc_pressure;
    s1_ah_r  <= in_adc_humidity;
  end

  // stage 2
  logic signed [31:0] s2_v1_r, s2_m_r;
  logic [19:0]        s2_ap_r;
  logic [15:0]        s2_ah_r;

  always_ff @(posedge clk) begin
    s2_v1_r <= s1_at2_r >>> 11;
    s2_m_r  <= (s1_bb_r >>> 12) * t3;
    s2_ap_r <= s1_ap_r;
    s2_ah_r <= s1_ah_r;
  end

  // stage 3: fine temperature
  logic signed [31:0] s3_tfine_r;
  logic [19:0]        s3_ap_r;
  logic [15:0]        s3_ah_r;

  always_ff @(posedge clk) begin
    s3_tfine_r <= s2_v1_r + (s2_m_r >>> 14);
    s3_ap_r    <= s2_ap_r;
    s3_ah_r    <= s2_ah_r;
  end

  // stage 4: centi temperature, pressure offset, humidity first terms
  logic signed [31:0] s4_tcent_r, s4_tfine_r;
  logic signed [32:0] s4_x1_r;
  logic signed [31:0] s4_hxa_r, s4_vh6_r, s4_vh3_r;
  logic [19:0]        s4_ap_r;
  logic signed [31:0] s4_v;

  assign s4_v = s3_tfine_r - sic_pkg::HUM_TOFS;

  always_ff @(posedge clk) begin
    s4_tcent_r <= (s3_tfine_r * 32'sd5 + 32'sd128) >>> 8;
    s4_tfine_r <= s3_tfine_r;
    s4_x1_r    <= 33'(s3_tfine_r) - 33'(sic_pkg::TFINE_OFS);
    s4_hxa_r   <= $signed({2'd0, s3_ah_r, 14'd0}) - (h4 <<< 20) - (h5 * s4_v)
                  + sic_pkg::HUM_RND14;
    s4_vh6_r   <= s4_v * h6;
    s4_vh3_r   <= s4_v * h3;
    s4_ap_r    <= s3_ap_r;
  end

  // stage 5
  logic signed [31:0] s5_tcent_r, s5_tfine_r;
  logic signed [63:0] s5_sq_r, s5_x1p5_r, s5_x1p2_r;
  logic signed [31:0] s5_hx_r, s5_hm_r;
  logic [19:0]        s5_ap_r;

  always_ff @(posedge clk) begin
    s5_tcent_r <= s4_tcent_r;
    s5_tfine_r <= s4_tfine_r;
    s5_sq_r    <= 64'(s4_x1_r) * 64'(s4_x1_r);
    s5_x1p5_r  <= 64'(s4_x1_r) * p5;
    s5_x1p2_r  <= 64'(s4_x1_r) * p2;
    s5_hx_r    <= s4_hxa_r >>> 15;
    s5_hm_r    <= (s4_vh6_r >>> 10) * ((s4_vh3_r >>> 11) + sic_pkg::HUM_K15);
    s5_ap_r    <= s4_ap_r;
  end

  // stage 6
  logic signed [31:0] s6_tcent_r, s6_tfine_r;
  logic signed [63:0] s6_x2a_r, s6_a3_r, s6_x1p5_r, s6_x1p2_r;
  logic signed [31:0] s6_hx_r, s6_hy2_r;
  logic [19:0]        s6_ap_r;

  always_ff @(posedge clk) begin
    s6_tcent_r <= s5_tcent_r;
    s6_tfine_r <= s5_tfine_r;
    s6_x2a_r   <= s5_sq_r * p6;
    s6_a3_r    <= s5_sq_r * p3;
    s6_x1p5_r  <= s5_x1p5_r;
    s6_x1p2_r  <= s5_x1p2_r;
    s6_hx_r    <= s5_hx_r;
    s6_hy2_r   <= ((s5_hm_r >>> 10) + sic_pkg::HUM_K21) * h2 + sic_pkg::HUM_RND13;
    s6_ap_r    <= s5_ap_r;
  end

  // stage 7
  logic signed [31:0] s7_tcent_r, s7_tfine_r;
  logic signed [63:0] s7_x2_r, s7_x1a_r;
  logic signed [31:0] s7_hv_r;
  logic [19:0]        s7_ap_r;

  always_ff @(posedge clk) begin
    s7_tcent_r <= s6_tcent_r;
    s7_tfine_r <= s6_tfine_r;
    s7_x2_r    <= s6_x2a_r + (s6_x1p5_r <<< 17) + (p4 <<< 35);
    s7_x1a_r   <= (s6_a3_r >>> 8) + (s6_x1p2_r <<< 12);
    s7_hv_r    <= s6_hx_r * (s6_hy2_r >>> 14);
    s7_ap_r    <= s6_ap_r;
  end

  // stage 8
  logic signed [31:0] s8_tcent_r, s8_tfine_r;
  logic signed [63:0] s8_prod_r, s8_n0_r;
  logic signed [31:0] s8_hv_r, s8_hsq_r;
  logic signed [31:0] s8_hs;
  logic signed [63:0] s8_pp;

  assign s8_hs = s7_hv_r >>> 15;
  assign s8_pp = sic_pkg::PRES_FULL - $signed({44'd0, s7_ap_r});

  always_ff @(posedge clk) begin
    s8_tcent_r <= s7_tcent_r;
    s8_tfine_r <= s7_tfine_r;
    s8_prod_r  <= (sic_pkg::PRES_ONE47 + s7_x1a_r) * p1;
    s8_n0_r    <= (s8_pp <<< 31) - s7_x2_r;
    s8_hv_r    <= s7_hv_r;
    s8_hsq_r   <= s8_hs * s8_hs;
  end

  // stage 9: humidity finish, pressure divisor and dividend
  logic signed [31:0] s9_tcent_r, s9_tfine_r;
  logic signed [63:0] s9_d_r, s9_num_r;
  logic [16:0]        s9_hum_r;
  logic signed [31:0] s9_hv;
  logic [31:0]        s9_hc;

  always_comb begin
    s9_hv = s8_hv_r - (((s8_hsq_r >>> 7) * h1) >>> 4);
    if (s9_hv[31]) begin
      s9_hc = '0;
    end else if (unsigned'(s9_hv) > sic_pkg::HUM_CLAMP) begin
      s9_hc = sic_pkg::HUM_CLAMP;
    end else begin
      s9_hc = unsigned'(s9_hv);
    end
  end

  always_ff @(posedge clk) begin
    s9_tcent_r <= s8_tcent_r;
    s9_tfine_r <= s8_tfine_r;
    s9_d_r     <= s8_prod_r >>> 33;
    s9_num_r   <= s8_n0_r * sic_pkg::PRES_SCALE;
    s9_hum_r   <= s9_hc[28:12];
  end

  // stage 10 feeds divider slot 0; slots 1..64 each resolve one quotient bit
  logic [63:0]        dv_rem_r  [0:sic_pkg::DivSteps];
  logic [63:0]        dv_nq_r   [0:sic_pkg::DivSteps];
  logic [63:0]        dv_d_r    [0:sic_pkg::DivSteps];
  sic_pkg::sic_side_t dv_side_r [0:sic_pkg::DivSteps];
  logic [sic_pkg::DivSteps:0] dv_vld_r;

  always_ff @(posedge clk) begin
    dv_rem_r[0]          <= '0;
    dv_nq_r[0]           <= s9_num_r[63] ? unsigned'(-s9_num_r) : unsigned'(s9_num_r);
    dv_d_r[0]            <= s9_d_r[63] ? unsigned'(-s9_d_r) : unsigned'(s9_d_r);
    dv_side_r[0].tcent   <= s9_tcent_r;
    dv_side_r[0].tfine   <= s9_tfine_r;
    dv_side_r[0].hum     <= s9_hum_r;
    dv_side_r[0].neg     <= s9_num_r[63] ^ s9_d_r[63];
    dv_side_r[0].invalid <= (s9_d_r == 64'sd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r <= '0;
    end else begin
      dv_vld_r <= {dv_vld_r[sic_pkg::DivSteps-1:0], vld_r[9]};
    end
  end

  for (genvar g = 0; g < sic_pkg::DivSteps; g++) begin : g_div
    logic [64:0] trial;
    logic        ge;
    logic [64:0] diff;

    always_comb begin
      trial = {dv_rem_r[g], dv_nq_r[g][63]};
      ge    = trial >= {1'b0, dv_d_r[g]};
      diff  = trial - {1'b0, dv_d_r[g]};
    end

    always_ff @(posedge clk) begin
      dv_rem_r[g+1]  <= ge ? diff[63:0] : trial[63:0];
      dv_nq_r[g+1]   <= {dv_nq_r[g][62:0], ge};
      dv_d_r[g+1]    <= dv_d_r[g];
      dv_side_r[g+1] <= dv_side_r[g];
    end
  end

  // finish stages, valid bits for 1..5
  logic [5:1] fv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else begin
      fv_r <= {fv_r[4:1], dv_vld_r[sic_pkg::DivSteps]};
    end
  end

  // finish 1: signed quotient
  sic_pkg::sic_side_t f1_side_r;
  logic signed [63:0] f1_p_r;
  logic signed [63:0] f1_q;

  assign f1_q = $signed(dv_nq_r[sic_pkg::DivSteps]);

  always_ff @(posedge clk) begin
    f1_side_r <= dv_side_r[sic_pkg::DivSteps];
    f1_p_r    <= dv_side_r[sic_pkg::DivSteps].neg ? -f1_q : f1_q;
  end

  // finish 2: two 32-bit partial products for the square of p >>> 13, and p times p8
  sic_pkg::sic_side_t f2_side_r;
  logic signed [63:0] f2_p_r, f2_p8p_r;
  logic [63:0]        f2_ll_r;
  logic [31:0]        f2_lh_r;
  logic [63:0]        f2_q13;

  assign f2_q13 = unsigned'(f1_p_r >>> 13);

  always_ff @(posedge clk) begin
    f2_side_r <= f1_side_r;
    f2_p_r    <= f1_p_r;
    f2_p8p_r  <= f1_p_r * p8;
    f2_ll_r   <= {32'd0, f2_q13[31:0]} * {32'd0, f2_q13[31:0]};
    f2_lh_r   <= f2_q13[31:0] * f2_q13[63:32];
  end

  // finish 3
  sic_pkg::sic_side_t f3_side_r;
  logic signed [63:0] f3_p_r, f3_p8p_r, f3_sq_r;

  always_ff @(posedge clk) begin
    f3_side_r <= f2_side_r;
    f3_p_r    <= f2_p_r;
    f3_p8p_r  <= f2_p8p_r;
    f3_sq_r   <= $signed(f2_ll_r + {f2_lh_r[30:0], 33'd0});
  end

  // finish 4
  sic_pkg::sic_side_t f4_side_r;
  logic signed [63:0] f4_p_r, f4_p8p_r, f4_s9_r;

  always_ff @(posedge clk) begin
    f4_side_r <= f3_side_r;
    f4_p_r    <= f3_p_r;
    f4_p8p_r  <= f3_p8p_r;
    f4_s9_r   <= f3_sq_r * p9;
  end

  // finish 5
  sic_pkg::sic_side_t f5_side_r;
  logic signed [63:0] f5_sum_r;

  always_ff @(posedge clk) begin
    f5_side_r <= f4_side_r;
    f5_sum_r  <= f4_p_r + (f4_s9_r >>> 25) + (f4_p8p_r >>> 19);
  end

  // finish 6: output register
  logic signed [63:0] f6_pres;

  assign f6_pres = (f5_sum_r >>> 8) + (p7 <<< 4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= fv_r[5];
    end
  end

  always_ff @(posedge clk) begin
    out_temperature_centi <= f5_side_r.tcent;
    out_fine_temperature  <= f5_side_r.tfine;
    out_humidity_q22_10   <= f5_side_r.hum;
    out_pressure_invalid  <= f5_side_r.invalid;
    out_pressure_q24_8    <= f5_side_r.invalid ? 32'd0 : unsigned'(f6_pres[31:0]);
  end

`ifndef ASSERT_OFF
  a_out_follows_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, sic_pkg::Latency))
    else $error("result word without matching input word");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pressure_invalid |-> out_pressure_q24_8 == 32'd0)
    else $error("invalid pressure not forced to zero");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_humidity_q22_10 <= sic_pkg::HUM_OUT_MAX)
    else $error("humidity outside clamp range");

  a_div_flag: assert property (@(posedge clk) disable iff (!rst_n)
    dv_vld_r[sic_pkg::DivSteps] |-> (dv_side_r[sic_pkg::DivSteps].invalid
                                     == (dv_d_r[sic_pkg::DivSteps] == 64'd0)))
    else $error("divider invalid flag lost its divisor");
`endif

endmodule

`default_nettype wire
